// ===== sv/iaa_pkg.sv =====
`timescale 1ns / 1ps
// Shared package of the accumulator ALU: word width, pipeline depths and opcodes.
// No dependencies; every other file imports it.
package iaa_pkg;

  localparam int WORD_BITS = 40;
  localparam int PROD_BITS = 2 * WORD_BITS;
  // The multiplier splits each operand into a 32-bit low part and a short high part.
  localparam int MUL_LO    = 32;
  localparam int MUL_HI    = WORD_BITS - MUL_LO;
  localparam int MUL_LAT   = 3;
  // One quotient bit per divider stage.
  localparam int DIV_LAT   = WORD_BITS;
  localparam int PIPE_LAT  = DIV_LAT;
  localparam int PROD_DLY  = PIPE_LAT - MUL_LAT;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_ADD_ABS = 4'd1,
    OP_SUB     = 4'd2,
    OP_SUB_ABS = 4'd3,
    OP_MUL     = 4'd4,
    OP_DIV     = 4'd5,
    OP_SHL     = 4'd6,
    OP_SHR     = 4'd7,
    OP_MBR_MQ  = 4'd8,
    OP_MQ_AC   = 4'd9,
    OP_MBR_AC  = 4'd10,
    OP_AC_MBR  = 4'd11
  } op_t;

endpackage

// ===== sv/iaa_mul.sv =====
`timescale 1ns / 1ps
// Three-stage unsigned multiplier for word magnitudes, built from four partial products.
// Depends on iaa_pkg.
module iaa_mul (
  input  logic          clk,
  input  logic          en,
  input  iaa_pkg::word_t a,
  input  iaa_pkg::word_t b,
  output iaa_pkg::prod_t p
);
  import iaa_pkg::*;

  logic [2*MUL_LO-1:0]      ll_r;
  logic [MUL_LO+MUL_HI-1:0] lh_r, hl_r;
  logic [2*MUL_HI-1:0]      hh_r;
  logic [2*MUL_LO-1:0]      ll2_r;
  logic [MUL_LO+MUL_HI:0]   mid_r;
  logic [2*MUL_HI-1:0]      hh2_r;
  prod_t                    p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= a[MUL_LO-1:0] * b[MUL_LO-1:0];
      lh_r  <= a[MUL_LO-1:0] * b[WORD_BITS-1:MUL_LO];
      hl_r  <= a[WORD_BITS-1:MUL_LO] * b[MUL_LO-1:0];
      hh_r  <= a[WORD_BITS-1:MUL_LO] * b[WORD_BITS-1:MUL_LO];
      ll2_r <= ll_r;
      hh2_r <= hh_r;
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
      p_r   <= PROD_BITS'(ll2_r) + (PROD_BITS'(mid_r) << MUL_LO)
             + (PROD_BITS'(hh2_r) << (2 * MUL_LO));
    end
  end

  assign p = p_r;

endmodule

// ===== sv/iaa_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider for word magnitudes, one quotient bit per stage.
// Depends on iaa_pkg.
module iaa_div (
  input  logic          clk,
  input  logic          en,
  input  iaa_pkg::word_t num,
  input  iaa_pkg::word_t den,
  output iaa_pkg::word_t quo,
  output iaa_pkg::word_t rem
);
  import iaa_pkg::*;

  word_t rem_r [DIV_LAT];
  word_t nq_r  [DIV_LAT];
  word_t den_r [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    word_t              rem_in, nq_in, den_in;
    logic [WORD_BITS:0] trial;
    logic [WORD_BITS:0] diff;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
    end
    assign trial = {rem_in, nq_in[WORD_BITS-1]};
    assign diff  = trial - {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in;
        if (!diff[WORD_BITS]) begin
          rem_r[i] <= diff[WORD_BITS-1:0];
          nq_r[i]  <= {nq_in[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_r[i] <= trial[WORD_BITS-1:0];
          nq_r[i]  <= {nq_in[WORD_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = nq_r[DIV_LAT-1];
  assign rem = rem_r[DIV_LAT-1];

endmodule

// ===== sv/ias_accumulator_alu_unit.sv =====
`timescale 1ns / 1ps
// Top level of the accumulator ALU: input register, multiplier, divider, output register.
// Depends on iaa_pkg, iaa_mul and iaa_div.
//
//   Channel | Direction | Ports
//   --------+-----------+-------------------------------------------------
//   in      | into unit | in_valid, in_stall, in_kind, in_ac_in, in_mq_in, in_mbr_in
//   out     | from unit | out_valid, out_stall, out_ac_out, out_mq_out, out_mbr_out
//
// Every word passes through the same fixed pipeline of 42 register stages: an input stage,
// 40 stages set by the divider (one quotient bit each), and the output register.
// One word can enter in every cycle while the output is not stalled; the divider's stage count sets the latency.
// rst_n is synchronous and clears only the valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline, and in_stall is raised in that same cycle,
// so no word is dropped or duplicated.
module ias_accumulator_alu_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   in_kind,
  input  logic signed [iaa_pkg::WORD_BITS-1:0] in_ac_in,
  input  logic signed [iaa_pkg::WORD_BITS-1:0] in_mq_in,
  input  logic signed [iaa_pkg::WORD_BITS-1:0] in_mbr_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [iaa_pkg::WORD_BITS-1:0] out_ac_out,
  output logic signed [iaa_pkg::WORD_BITS-1:0] out_mq_out,
  output logic signed [iaa_pkg::WORD_BITS-1:0] out_mbr_out
);
  import iaa_pkg::*;

  // The pipeline moves whenever the output register is empty or being taken.
  logic out_valid_r;
  logic adv;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Input stage: the operands, their magnitudes and their signs.
  logic       p0_v_r;
  logic [3:0] p0_kind_r;
  word_t      p0_ac_r, p0_mq_r, p0_mbr_r, p0_ma_r, p0_mb_r;
  logic       p0_sa_r, p0_sb_r;
  word_t      ma_nxt, mb_nxt;

  always_comb begin
    ma_nxt = in_ac_in[WORD_BITS-1]  ? word_t'(-in_ac_in)  : word_t'(in_ac_in);
    mb_nxt = in_mbr_in[WORD_BITS-1] ? word_t'(-in_mbr_in) : word_t'(in_mbr_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else if (adv) begin
      p0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_kind_r <= in_kind;
      p0_ac_r   <= in_ac_in;
      p0_mq_r   <= in_mq_in;
      p0_mbr_r  <= in_mbr_in;
      p0_ma_r   <= ma_nxt;
      p0_mb_r   <= mb_nxt;
      p0_sa_r   <= in_ac_in[WORD_BITS-1];
      p0_sb_r   <= in_mbr_in[WORD_BITS-1];
    end
  end

  // The simple operations finish here; multiply and divide keep the old values for now,
  // which is also the answer for a zero divisor.
  word_t s_ac_nxt, s_mq_nxt, s_mbr_nxt;

  always_comb begin
    s_ac_nxt  = p0_ac_r;
    s_mq_nxt  = p0_mq_r;
    s_mbr_nxt = p0_mbr_r;
    case (p0_kind_r)
      OP_ADD:     s_ac_nxt = p0_ac_r + p0_mbr_r;
      OP_ADD_ABS: begin
        s_mbr_nxt = p0_mb_r;
        s_ac_nxt  = p0_ac_r + p0_mb_r;
      end
      OP_SUB:     s_ac_nxt = p0_ac_r - p0_mbr_r;
      OP_SUB_ABS: begin
        s_mbr_nxt = p0_mb_r;
        s_ac_nxt  = p0_ac_r - p0_mb_r;
      end
      OP_SHL:     s_ac_nxt = {p0_ac_r[WORD_BITS-2:0], 1'b0};
      OP_SHR:     s_ac_nxt = {p0_ac_r[WORD_BITS-1], p0_ac_r[WORD_BITS-1:1]};
      OP_MBR_MQ:  s_mq_nxt = p0_mbr_r;
      OP_MQ_AC:   s_ac_nxt = p0_mq_r;
      OP_MBR_AC:  s_ac_nxt = p0_mbr_r;
      OP_AC_MBR:  s_mbr_nxt = p0_ac_r;
      default:    ;
    endcase
  end

  // Delay line that keeps the control and the simple results in step with the divider.
  logic       dl_v_r    [PIPE_LAT];
  logic [3:0] dl_kind_r [PIPE_LAT];
  logic       dl_sa_r   [PIPE_LAT];
  logic       dl_sb_r   [PIPE_LAT];
  logic       dl_dz_r   [PIPE_LAT];
  word_t      dl_ac_r   [PIPE_LAT];
  word_t      dl_mq_r   [PIPE_LAT];
  word_t      dl_mbr_r  [PIPE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) dl_v_r[i] <= 1'b0;
    end else if (adv) begin
      dl_v_r[0] <= p0_v_r;
      for (int i = 1; i < PIPE_LAT; i++) dl_v_r[i] <= dl_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_kind_r[0] <= p0_kind_r;
      dl_sa_r[0]   <= p0_sa_r;
      dl_sb_r[0]   <= p0_sb_r;
      dl_dz_r[0]   <= (p0_mbr_r == '0);
      dl_ac_r[0]   <= s_ac_nxt;
      dl_mq_r[0]   <= s_mq_nxt;
      dl_mbr_r[0]  <= s_mbr_nxt;
      for (int i = 1; i < PIPE_LAT; i++) begin
        dl_kind_r[i] <= dl_kind_r[i-1];
        dl_sa_r[i]   <= dl_sa_r[i-1];
        dl_sb_r[i]   <= dl_sb_r[i-1];
        dl_dz_r[i]   <= dl_dz_r[i-1];
        dl_ac_r[i]   <= dl_ac_r[i-1];
        dl_mq_r[i]   <= dl_mq_r[i-1];
        dl_mbr_r[i]  <= dl_mbr_r[i-1];
      end
    end
  end

  // Multiplier on the magnitudes; its product then waits for the divider's latency.
  prod_t mul_p;
  prod_t pd_r [PROD_DLY];

  iaa_mul u_mul (
    .clk (clk),
    .en  (adv),
    .a   (p0_ma_r),
    .b   (p0_mb_r),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pd_r[0] <= mul_p;
      for (int i = 1; i < PROD_DLY; i++) pd_r[i] <= pd_r[i-1];
    end
  end

  // Divider on the magnitudes.
  word_t div_q, div_r;

  iaa_div u_div (
    .clk (clk),
    .en  (adv),
    .num (p0_ma_r),
    .den (p0_mb_r),
    .quo (div_q),
    .rem (div_r)
  );

  // Final stage: sign correction of the product or quotient and remainder, then select.
  word_t out_ac_r, out_mq_r, out_mbr_r;
  word_t f_ac_nxt, f_mq_nxt;
  prod_t sp;

  always_comb begin
    sp       = (dl_sa_r[PIPE_LAT-1] ^ dl_sb_r[PIPE_LAT-1]) ? -pd_r[PROD_DLY-1]
                                                           : pd_r[PROD_DLY-1];
    f_ac_nxt = dl_ac_r[PIPE_LAT-1];
    f_mq_nxt = dl_mq_r[PIPE_LAT-1];
    case (dl_kind_r[PIPE_LAT-1])
      OP_MUL: begin
        f_ac_nxt = sp[PROD_BITS-1:WORD_BITS];
        f_mq_nxt = sp[WORD_BITS-1:0];
      end
      OP_DIV: begin
        if (!dl_dz_r[PIPE_LAT-1]) begin
          f_mq_nxt = (dl_sa_r[PIPE_LAT-1] ^ dl_sb_r[PIPE_LAT-1]) ? -div_q : div_q;
          f_ac_nxt = dl_sa_r[PIPE_LAT-1] ? -div_r : div_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dl_v_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ac_r  <= f_ac_nxt;
      out_mq_r  <= f_mq_nxt;
      out_mbr_r <= dl_mbr_r[PIPE_LAT-1];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ac_out  = out_ac_r;
  assign out_mq_out  = out_mq_r;
  assign out_mbr_out = out_mbr_r;

endmodule

// ===== sv/iaa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the accumulator ALU, attached to the top level by bind.
// Depends on iaa_pkg and ias_accumulator_alu_unit.
module iaa_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input iaa_pkg::word_t         out_ac_out
);
  import iaa_pkg::*;

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a held output word");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word withdrawn");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ac_out))
    else $error("stalled output word changed");

endmodule

bind ias_accumulator_alu_unit iaa_checker u_iaa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_ac_out (out_ac_out)
);
